// ===== hw/rtl/reinhard_tonemap_pixel_top_assert.svh =====
// Assertion macros for the tone-map pixel pipeline.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef REINHARD_TONEMAP_PIXEL_TOP_ASSERT_SVH
`define REINHARD_TONEMAP_PIXEL_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define RTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen outside reset
`define RTP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/rtp_pkg.sv =====
// Shared constants, types and the exp2 root table function for the tone-map pipeline.
// No dependencies.
`timescale 1ns / 1ps
package rtp_pkg;

	localparam int IN_W   = 24;
	localparam int OUT_W  = 16;
	localparam int REG_W  = 16;
	localparam int C_W    = IN_W + REG_W;
	localparam int D_W    = C_W + 1;
	localparam int PROD_W = C_W + 16;
	localparam int SUM_W  = PROD_W + 2;
	localparam int CFRAC  = 20;

	localparam int DIV_STEPS  = 17;
	localparam int LOG_STEPS  = 16;
	localparam int GDIV_STEPS = 33;
	localparam int EXP_STEPS  = 16;
	localparam int FRONT_LAT  = 3;
	localparam int CH_LAT     = DIV_STEPS + LOG_STEPS + GDIV_STEPS + EXP_STEPS + 5;
	localparam int TOT_LAT    = FRONT_LAT + CH_LAT;
	localparam int SH_BASE    = 30 - OUT_W - 1;

	localparam logic [15:0] W_RED   = 16'd13938;
	localparam logic [15:0] W_GREEN = 16'd46868;
	localparam logic [15:0] W_BLUE  = 16'd4730;

	localparam logic [REG_W-1:0] EXPOSURE_RST = 16'd256;
	localparam logic [REG_W-1:0] GAMMA_RST    = 16'd9011;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA    = 1'd1;

	typedef logic [C_W-1:0] rtp_c_t;

	typedef struct packed {
		logic   vld;
		rtp_c_t lum;
		rtp_c_t r;
		rtp_c_t g;
		rtp_c_t b;
	} rtp_pix_t;

	// hit: result is decided early; sat: decided value is full scale
	typedef struct packed {
		logic hit;
		logic sat;
	} rtp_flag_t;

	// 2^(-2^-k) in Q.30, built by k repeated integer square roots from one half
	function automatic logic [29:0] rtp_root(input int k);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		logic [63:0] r;
		r = 64'd1 << 29;
		for (int i = 1; i <= k; i++) begin
			v   = r << 30;
			res = '0;
			bt  = 64'd1 << 62;
			while (bt > v)
				bt = bt >> 2;
			while (bt != 0) begin
				if (v >= res + bt) begin
					v   = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			r = res;
		end
		return r[29:0];
	endfunction

endpackage

// ===== hw/rtl/rtp_front.sv =====
// Exposure scaling and luminance: three register stages.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
module rtp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rtp_pkg::IN_W-1:0]  red,
	input  logic [rtp_pkg::IN_W-1:0]  green,
	input  logic [rtp_pkg::IN_W-1:0]  blue,
	input  logic [rtp_pkg::REG_W-1:0] exposure,
	output rtp_pkg::rtp_pix_t         pix
);
	import rtp_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	rtp_c_t cr_s1, cg_s1, cb_s1;
	rtp_c_t cr_s2, cg_s2, cb_s2;
	logic [PROD_W-1:0] pr_s2, pg_s2, pb_s2;
	rtp_c_t cr_s3, cg_s3, cb_s3, lum_s3;
	logic [SUM_W-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign sum = SUM_W'(pr_s2) + SUM_W'(pg_s2) + SUM_W'(pb_s2);

	always_ff @(posedge clk) begin
		cr_s1  <= C_W'(red) * C_W'(exposure);
		cg_s1  <= C_W'(green) * C_W'(exposure);
		cb_s1  <= C_W'(blue) * C_W'(exposure);
		pr_s2  <= PROD_W'(W_RED) * PROD_W'(cr_s1);
		pg_s2  <= PROD_W'(W_GREEN) * PROD_W'(cg_s1);
		pb_s2  <= PROD_W'(W_BLUE) * PROD_W'(cb_s1);
		cr_s2  <= cr_s1;
		cg_s2  <= cg_s1;
		cb_s2  <= cb_s1;
		lum_s3 <= sum[16 +: C_W];
		cr_s3  <= cr_s2;
		cg_s3  <= cg_s2;
		cb_s3  <= cb_s2;
	end

	assign pix.vld = vld_s3;
	assign pix.lum = lum_s3;
	assign pix.r   = cr_s3;
	assign pix.g   = cg_s3;
	assign pix.b   = cb_s3;

endmodule

// ===== hw/rtl/rtp_chan.sv =====
// One color channel: C/(1+L) division, log2, divide by gamma, exp2 and rounding.
// Depends on rtp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "reinhard_tonemap_pixel_top_assert.svh"
module rtp_chan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_vld,
	input  logic [rtp_pkg::C_W-1:0]   chan,
	input  logic [rtp_pkg::C_W-1:0]   lum,
	input  logic [rtp_pkg::REG_W-1:0] gamma,
	output logic                      res_vld,
	output logic [rtp_pkg::OUT_W-1:0] res
);
	import rtp_pkg::*;

	localparam logic [OUT_W-1:0] MAXV  = '1;
	localparam logic [D_W-1:0]   ONE_C = D_W'(1) << CFRAC;

	logic [D_W-1:0] d_w;
	rtp_flag_t      in_flag;

	// luminance division stages
	logic [D_W-1:0]       div_rem_s  [0:DIV_STEPS];
	logic [D_W-1:0]       div_d_s    [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] div_q_s    [0:DIV_STEPS];
	rtp_flag_t            div_flag_s [0:DIV_STEPS];
	logic [DIV_STEPS:0]   div_vld_s;

	// log2 squaring stages
	logic [30:0] log_m_s    [0:LOG_STEPS];
	logic [3:0]  log_p_s    [0:LOG_STEPS];
	logic [15:0] log_fr_s   [0:LOG_STEPS];
	rtp_flag_t   log_flag_s [0:LOG_STEPS];
	logic [LOG_STEPS:0] log_vld_s;

	// gamma division stages
	logic [15:0] gd_rem_s  [0:GDIV_STEPS];
	logic [32:0] gd_num_s  [0:GDIV_STEPS];
	logic [32:0] gd_quo_s  [0:GDIV_STEPS];
	rtp_flag_t   gd_flag_s [0:GDIV_STEPS];
	logic [GDIV_STEPS:0] gd_vld_s;

	// exp2 product stages
	logic [30:0] ex_y_s    [0:EXP_STEPS];
	logic [15:0] ex_r_s    [0:EXP_STEPS];
	logic [4:0]  ex_n_s    [0:EXP_STEPS];
	rtp_flag_t   ex_flag_s [0:EXP_STEPS];
	logic [EXP_STEPS:0] ex_vld_s;

	// ---------------- entry ----------------
	always_comb begin
		d_w = ONE_C + D_W'(lum);
		in_flag.hit = 1'b0;
		in_flag.sat = 1'b0;
		if (lum == '0 || chan == '0) begin
			in_flag.hit = 1'b1;
		end else if (D_W'(chan) >= d_w) begin
			in_flag.hit = 1'b1;
			in_flag.sat = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		div_rem_s[0]  <= D_W'(chan);
		div_d_s[0]    <= d_w;
		div_q_s[0]    <= '0;
		div_flag_s[0] <= in_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else begin
			div_vld_s[0] <= pix_vld;
		end
	end

	// ---------------- restoring division, one quotient bit a stage ----------------
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		logic [D_W:0] sh;
		logic         ge;
		logic [D_W:0] diff;

		always_comb begin
			sh   = {div_rem_s[i], 1'b0};
			ge   = sh >= {1'b0, div_d_s[i]};
			diff = sh - {1'b0, div_d_s[i]};
		end

		always_ff @(posedge clk) begin
			div_rem_s[i+1]  <= ge ? diff[D_W-1:0] : sh[D_W-1:0];
			div_d_s[i+1]    <= div_d_s[i];
			div_q_s[i+1]    <= {div_q_s[i][DIV_STEPS-2:0], ge};
			div_flag_s[i+1] <= div_flag_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i+1] <= 1'b0;
			end else begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
		end
	end

	// ---------------- round to Q0.16, normalize for log2 ----------------
	logic [DIV_STEPS:0] xr;
	logic [15:0]        x16;
	logic [3:0]         lead;
	rtp_flag_t          norm_flag;

	always_comb begin
		xr  = ({1'b0, div_q_s[DIV_STEPS]} + 18'd1) >> 1;
		x16 = xr[15:0];
		lead = '0;
		for (int b = 0; b < 16; b++) begin
			if (x16[b])
				lead = 4'(b);
		end
		norm_flag = div_flag_s[DIV_STEPS];
		if (!norm_flag.hit) begin
			if (xr[16]) begin
				norm_flag.hit = 1'b1;
				norm_flag.sat = 1'b1;
			end else if (x16 == '0 || gamma == '0) begin
				norm_flag.hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		log_m_s[0]    <= 31'(x16) << (5'd30 - {1'b0, lead});
		log_p_s[0]    <= lead;
		log_fr_s[0]   <= '0;
		log_flag_s[0] <= norm_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_vld_s[0] <= 1'b0;
		end else begin
			log_vld_s[0] <= div_vld_s[DIV_STEPS];
		end
	end

	// ---------------- log2 mantissa: one squaring a stage ----------------
	for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
		logic [61:0] prod;
		logic [31:0] sq;
		logic [15:0] fr;

		always_comb begin
			prod = 62'(log_m_s[j]) * 62'(log_m_s[j]);
			sq   = prod[61:30];
			fr   = log_fr_s[j];
			fr[15-j] = sq[31];
		end

		always_ff @(posedge clk) begin
			log_m_s[j+1]    <= sq[31] ? sq[31:1] : sq[30:0];
			log_p_s[j+1]    <= log_p_s[j];
			log_fr_s[j+1]   <= fr;
			log_flag_s[j+1] <= log_flag_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				log_vld_s[j+1] <= 1'b0;
			end else begin
				log_vld_s[j+1] <= log_vld_s[j];
			end
		end
	end

	// ---------------- -log2(x) << 12 plus half of gamma ----------------
	logic [20:0] neg;
	logic [32:0] num;

	always_comb begin
		neg = 21'h10_0000 - 21'({log_p_s[LOG_STEPS], log_fr_s[LOG_STEPS]});
		num = {neg, 12'd0} + 33'(gamma[REG_W-1:1]);
	end

	always_ff @(posedge clk) begin
		gd_rem_s[0]  <= '0;
		gd_num_s[0]  <= num;
		gd_quo_s[0]  <= '0;
		gd_flag_s[0] <= log_flag_s[LOG_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gd_vld_s[0] <= 1'b0;
		end else begin
			gd_vld_s[0] <= log_vld_s[LOG_STEPS];
		end
	end

	// ---------------- divide by gamma, one quotient bit a stage ----------------
	for (genvar k = 0; k < GDIV_STEPS; k++) begin : g_gdiv
		logic [16:0] part;
		logic        ge;
		logic [16:0] diff;

		always_comb begin
			part = {gd_rem_s[k], gd_num_s[k][32]};
			ge   = part >= {1'b0, gamma};
			diff = part - {1'b0, gamma};
		end

		always_ff @(posedge clk) begin
			gd_rem_s[k+1]  <= ge ? diff[15:0] : part[15:0];
			gd_num_s[k+1]  <= {gd_num_s[k][31:0], 1'b0};
			gd_quo_s[k+1]  <= {gd_quo_s[k][31:0], ge};
			gd_flag_s[k+1] <= gd_flag_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				gd_vld_s[k+1] <= 1'b0;
			end else begin
				gd_vld_s[k+1] <= gd_vld_s[k];
			end
		end
	end

	// ---------------- split t into integer shift and fraction ----------------
	logic [16:0] t_int;
	rtp_flag_t   exp_flag;

	always_comb begin
		t_int    = gd_quo_s[GDIV_STEPS][32:16];
		exp_flag = gd_flag_s[GDIV_STEPS];
		// drop to black when the shift runs past the word
		if (!exp_flag.hit && t_int > 17'd30)
			exp_flag.hit = 1'b1;
	end

	always_ff @(posedge clk) begin
		ex_y_s[0]    <= 31'd1 << 30;
		ex_r_s[0]    <= gd_quo_s[GDIV_STEPS][15:0];
		ex_n_s[0]    <= t_int[4:0];
		ex_flag_s[0] <= exp_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_vld_s[0] <= 1'b0;
		end else begin
			ex_vld_s[0] <= gd_vld_s[GDIV_STEPS];
		end
	end

	// ---------------- exp2 of the fraction: one root product a stage ----------------
	for (genvar e = 0; e < EXP_STEPS; e++) begin : g_exp
		localparam logic [29:0] RC = rtp_root(e + 1);
		logic [61:0] prod;

		always_comb begin
			prod = 62'(ex_y_s[e]) * 62'(RC) + (62'd1 << 29);
		end

		always_ff @(posedge clk) begin
			ex_y_s[e+1]    <= ex_r_s[e][15-e] ? prod[60:30] : ex_y_s[e];
			ex_r_s[e+1]    <= ex_r_s[e];
			ex_n_s[e+1]    <= ex_n_s[e];
			ex_flag_s[e+1] <= ex_flag_s[e];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_vld_s[e+1] <= 1'b0;
			end else begin
				ex_vld_s[e+1] <= ex_vld_s[e];
			end
		end
	end

	// ---------------- shift by integer part, round, clamp ----------------
	logic [5:0]  sha;
	logic [30:0] t1;
	logic [31:0] r1;
	logic [OUT_W-1:0] fin;
	rtp_flag_t   fin_flag;

	always_comb begin
		sha = 6'(SH_BASE) + {1'b0, ex_n_s[EXP_STEPS]};
		t1  = ex_y_s[EXP_STEPS] >> sha;
		r1  = (32'(t1) + 32'd1) >> 1;
		fin_flag = ex_flag_s[EXP_STEPS];
		if (fin_flag.hit)
			fin = fin_flag.sat ? MAXV : '0;
		else if (r1 > 32'(MAXV))
			fin = MAXV;
		else
			fin = r1[OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		res <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld <= 1'b0;
		end else begin
			res_vld <= ex_vld_s[EXP_STEPS];
		end
	end

	`RTP_ASSERT(a_black_on_zero_lum, pix_vld && lum == '0 |-> ##CH_LAT (res_vld && res == '0), "zero luminance did not give black")
	`RTP_ASSERT(a_sat_above_one, pix_vld && lum != '0 && chan != '0 && D_W'(chan) >= d_w |-> ##CH_LAT (res_vld && res == MAXV), "value at or above one did not saturate")

endmodule

// ===== hw/rtl/reinhard_tonemap_pixel_top.sv =====
// Top level of the Reinhard tone-map pixel pipeline: config registers and channel lanes.
// Depends on rtp_pkg, rtp_front, rtp_chan and the assertion macro header.
`timescale 1ns / 1ps
`include "reinhard_tonemap_pixel_top_assert.svh"
// One pixel is taken on every clock in which start is high; busy stays low. Results
// appear on done and the output ports in order, one per cycle at full rate, and the
// receiver cannot stall them. Each pixel passes through 3 shared front stages (exposure,
// weights, luminance sum), then in each channel lane 17 stages of the C/(1+L) divider,
// 16 log2 squaring stages, 33 stages of the gamma divider, 16 exp2 product stages and
// 5 glue stages. Write exposure and gamma only while no pixel is in flight.
module reinhard_tonemap_pixel_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rtp_pkg::IN_W-1:0]      red_in,
	input  logic [rtp_pkg::IN_W-1:0]      green_in,
	input  logic [rtp_pkg::IN_W-1:0]      blue_in,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtp_pkg::REG_W-1:0]     cfg_data,
	output logic                          done,
	output logic [rtp_pkg::OUT_W-1:0]     red_out,
	output logic [rtp_pkg::OUT_W-1:0]     green_out,
	output logic [rtp_pkg::OUT_W-1:0]     blue_out
);
	import rtp_pkg::*;

	logic [REG_W-1:0] exposure_q;
	logic [REG_W-1:0] gamma_q;
	rtp_pix_t         pix;
	logic             g_vld;
	logic             b_vld;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_q <= EXPOSURE_RST;
			gamma_q    <= GAMMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPOSURE: exposure_q <= cfg_data;
				REG_GAMMA:    gamma_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	rtp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !busy),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.exposure (exposure_q),
		.pix      (pix)
	);

	rtp_chan u_chan_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_vld (pix.vld),
		.chan    (pix.r),
		.lum     (pix.lum),
		.gamma   (gamma_q),
		.res_vld (done),
		.res     (red_out)
	);

	rtp_chan u_chan_g (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_vld (pix.vld),
		.chan    (pix.g),
		.lum     (pix.lum),
		.gamma   (gamma_q),
		.res_vld (g_vld),
		.res     (green_out)
	);

	rtp_chan u_chan_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_vld (pix.vld),
		.chan    (pix.b),
		.lum     (pix.lum),
		.gamma   (gamma_q),
		.res_vld (b_vld),
		.res     (blue_out)
	);

	`RTP_ASSERT(a_fixed_latency, start && !busy |-> ##TOT_LAT done, "result missing at fixed latency")
	`RTP_ASSERT_NEVER(a_lanes_aligned, done != g_vld || done != b_vld, "channel lanes out of step")

endmodule
